[rtl/rcs_pkg.sv]
// shared types, codes and keyword tables for the recursion call spotter
package rcs_pkg;

  localparam int NAME_CHARS = 8;
  localparam int NAME_BITS  = 8 * NAME_CHARS;
  localparam int NIDX_BITS  = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
  localparam int DEPTH_BITS = 8;
  localparam int WLEN_BITS  = 4;
  localparam int LEN_BITS   = 4;
  localparam int NUM_KW     = 4;

  localparam logic [WLEN_BITS-1:0] WLEN_MAX       = {WLEN_BITS{1'b1}};
  localparam logic [WLEN_BITS-1:0] NAME_CHARS_LEN = WLEN_BITS'(NAME_CHARS);
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX     = {DEPTH_BITS{1'b1}};

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // register indexes
  localparam logic REG_TARGET_NAME   = 1'b0;
  localparam logic REG_TARGET_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_NOT_RECURSIVE = 2'd0,
    VERDICT_RECURSIVE     = 2'd1,
    VERDICT_NOT_FOUND     = 2'd2
  } verdict_e;

  typedef enum logic [4:0] {
    PH_KEYWORD = 5'b00001,
    PH_NAME    = 5'b00010,
    PH_BRACE   = 5'b00100,
    PH_BODY    = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_e;

  // one classified character
  typedef struct packed {
    logic [7:0] ch;
    logic       letter;
    logic       lbrace;
    logic       rbrace;
    logic       eot;
  } char_beat_t;

  localparam logic [WLEN_BITS-1:0] KW_LEN [NUM_KW] = '{4'd3, 4'd5, 4'd4, 4'd4};

  // letter p of keyword k: int, float, void, bool
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [WLEN_BITS-1:0] p);
    logic [7:0] r;
    r = 8'h00;
    unique case (k)
      2'd0: begin
        case (p)
          4'd0: r = "i";
          4'd1: r = "n";
          4'd2: r = "t";
          default: r = 8'h00;
        endcase
      end
      2'd1: begin
        case (p)
          4'd0: r = "f";
          4'd1: r = "l";
          4'd2: r = "o";
          4'd3: r = "a";
          4'd4: r = "t";
          default: r = 8'h00;
        endcase
      end
      2'd2: begin
        case (p)
          4'd0: r = "v";
          4'd1: r = "o";
          4'd2: r = "i";
          4'd3: r = "d";
          default: r = 8'h00;
        endcase
      end
      default: begin
        case (p)
          4'd0: r = "b";
          4'd1: r = "o";
          4'd2: r = "o";
          4'd3: r = "l";
          default: r = 8'h00;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/rcs_front.sv]
// input side: accepts character beats and classifies them
module rcs_front (
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // text_char
  input  logic                s_axis_tlast,   // end_of_text
  input  logic                q_ready_i,
  output logic                q_push_o,
  output rcs_pkg::char_beat_t q_beat_o
);
  import rcs_pkg::*;

  logic upper, lower;

  assign upper = (s_axis_tdata >= 8'h41) && (s_axis_tdata <= 8'h5A);
  assign lower = (s_axis_tdata >= 8'h61) && (s_axis_tdata <= 8'h7A);

  assign s_axis_tready   = q_ready_i;
  assign q_push_o        = s_axis_tvalid && q_ready_i;
  assign q_beat_o.ch     = s_axis_tdata;
  assign q_beat_o.letter = upper || lower;
  assign q_beat_o.lbrace = (s_axis_tdata == CH_LBRACE);
  assign q_beat_o.rbrace = (s_axis_tdata == CH_RBRACE);
  assign q_beat_o.eot    = s_axis_tlast;

endmodule

[rtl/rcs_fifo.sv]
// two-entry queue of classified beats between front and back
module rcs_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rcs_pkg::char_beat_t push_beat_i,
  output logic                ready_o,
  input  logic                pop_i,
  output logic                valid_o,
  output rcs_pkg::char_beat_t pop_beat_o
);
  import rcs_pkg::*;

  char_beat_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign ready_o    = (count_q != 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_beat_o = mem_q[rd_ptr_q];
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_beat_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q != 2'd2) else $error("push into full queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");

endmodule

[rtl/rcs_back.sv]
// scanner: word matching, phase tracking, brace depth and verdict register
module rcs_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [rcs_pkg::NAME_BITS-1:0]  cfg_data_i,
  input  logic                           q_valid_i,
  input  rcs_pkg::char_beat_t            q_beat_i,
  output logic                           q_pop_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata   // verdict, zero padded
);
  import rcs_pkg::*;

  logic [NAME_BITS-1:0]  target_name_q;
  logic [LEN_BITS-1:0]   target_length_q;

  phase_e                phase_q, phase_d;
  logic [WLEN_BITS-1:0]  wl_q, wl_d;
  logic [NUM_KW-1:0]     kc_q, kc_d;
  logic                  nc_q, nc_d;
  logic [DEPTH_BITS-1:0] depth_q, depth_d;
  logic                  out_valid_q, out_valid_d;
  verdict_e              out_verdict_q, out_verdict_d;

  logic                  fire;
  logic [WLEN_BITS-1:0]  wl_ext;
  logic [NUM_KW-1:0]     kc_ext, kw_len_hit;
  logic                  nc_ext, kw_hit, name_hit, word_end, produce;
  logic [7:0]            name_char;
  phase_e                phase_w;
  verdict_e              verdict;

  assign q_pop_o       = !out_valid_q || m_axis_tready;
  assign fire          = q_valid_i && q_pop_o;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_verdict_q};

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_name_q   <= '0;
      target_length_q <= LEN_BITS'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TARGET_NAME:   target_name_q   <= cfg_data_i;
        REG_TARGET_LENGTH: target_length_q <= cfg_data_i[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign name_char = target_name_q[8 * wl_q[NIDX_BITS-1:0] +: 8];

  // extend the open word by this letter
  always_comb begin
    kc_ext = kc_q;
    nc_ext = nc_q;
    wl_ext = wl_q;
    if (q_beat_i.letter) begin
      if (wl_q == '0) begin
        kc_ext = '1;
        nc_ext = 1'b1;
      end
      for (int k = 0; k < NUM_KW; k++) begin
        if (!(wl_q < KW_LEN[k] && kw_char(2'(k), wl_q) == q_beat_i.ch)) begin
          kc_ext[k] = 1'b0;
        end
      end
      if (!(wl_q < NAME_CHARS_LEN && name_char == q_beat_i.ch)) begin
        nc_ext = 1'b0;
      end
      if (wl_q != WLEN_MAX) begin
        wl_ext = wl_q + 1'b1;
      end
    end
    for (int k = 0; k < NUM_KW; k++) begin
      kw_len_hit[k] = (wl_ext == KW_LEN[k]);
    end
  end

  assign kw_hit   = |(kc_ext & kw_len_hit);
  assign name_hit = nc_ext && (wl_ext == target_length_q);
  assign word_end = (wl_ext != '0) && (!q_beat_i.letter || q_beat_i.eot);

  always_comb begin
    phase_d       = phase_q;
    wl_d          = wl_q;
    kc_d          = kc_q;
    nc_d          = nc_q;
    depth_d       = depth_q;
    produce       = 1'b0;
    verdict       = VERDICT_NOT_FOUND;
    phase_w       = phase_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_verdict_d = out_verdict_q;

    if (fire) begin
      if (phase_q != PH_DONE) begin
        wl_d = wl_ext;
        kc_d = kc_ext;
        nc_d = nc_ext;
        if (word_end) begin
          wl_d = '0;
          kc_d = '0;
          nc_d = 1'b0;
          unique case (phase_q)
            PH_KEYWORD: if (kw_hit) phase_w = PH_NAME;
            PH_NAME:    phase_w = name_hit ? PH_BRACE : PH_KEYWORD;
            PH_BODY: begin
              if (name_hit) begin
                produce = 1'b1;
                verdict = VERDICT_RECURSIVE;
                phase_w = PH_DONE;
              end
            end
            default: ;
          endcase
        end
        phase_d = phase_w;
        // the character that ended a word is still looked at as a brace
        if (!q_beat_i.letter) begin
          if (phase_w == PH_BRACE && q_beat_i.lbrace) begin
            depth_d = DEPTH_BITS'(1);
            phase_d = PH_BODY;
          end else if (phase_w == PH_BODY) begin
            if (q_beat_i.lbrace) begin
              if (depth_q != DEPTH_MAX) depth_d = depth_q + 1'b1;
            end else if (q_beat_i.rbrace) begin
              if (depth_q <= DEPTH_BITS'(1)) begin
                depth_d = '0;
                produce = 1'b1;
                verdict = VERDICT_NOT_RECURSIVE;
                phase_d = PH_DONE;
              end else begin
                depth_d = depth_q - 1'b1;
              end
            end
          end
        end
        if (q_beat_i.eot && !produce) begin
          produce = 1'b1;
          verdict = VERDICT_NOT_FOUND;
        end
      end
      if (q_beat_i.eot) begin
        phase_d = PH_KEYWORD;
        wl_d    = '0;
        kc_d    = '0;
        nc_d    = 1'b0;
        depth_d = '0;
      end
      if (produce) begin
        out_valid_d   = 1'b1;
        out_verdict_d = verdict;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_KEYWORD;
      wl_q          <= '0;
      kc_q          <= '0;
      nc_q          <= 1'b0;
      depth_q       <= '0;
      out_valid_q   <= 1'b0;
      out_verdict_q <= VERDICT_NOT_FOUND;
    end else begin
      phase_q       <= phase_d;
      wl_q          <= wl_d;
      kc_q          <= kc_d;
      nc_q          <= nc_d;
      depth_q       <= depth_d;
      out_valid_q   <= out_valid_d;
      out_verdict_q <= out_verdict_d;
    end
  end

  a_body_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> depth_q != '0) else $error("empty depth inside body");
  a_idle_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wl_q == '0 |-> (kc_q == '0 && !nc_q)) else $error("match flags without word");
  a_outside_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_KEYWORD || phase_q == PH_NAME || phase_q == PH_BRACE)
    |-> depth_q == '0) else $error("depth held outside body");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !fire) else $error("result overwritten");

endmodule

[rtl/recursion_call_spotter_top.sv]
// top level of the recursion call spotter: front, queue and scanner
//
//  channel   dir  data                              control
//  s_axis    in   tdata[7:0] text_char              tvalid/tready, tlast end_of_text
//  m_axis    out  tdata[1:0] verdict                tvalid/tready
//  cfg       in   cfg_data_i (64b), cfg_index_i     cfg_we_i, no handshake
//
// one character per cycle sustained while the verdict output is not stalled; a
// taken character is registered in a two-entry queue before it reaches the scanner.
// the verdict register holds at most one result; while it is stalled the
// scanner stops and the queue absorbs up to two further characters.
// reset clears all scan state; target_length resets to 1, target_name to 0.
module recursion_call_spotter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_char
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // verdict [1:0], zeros above
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import rcs_pkg::*;

  logic       q_ready, q_push, q_valid, q_pop;
  char_beat_t push_beat, pop_beat;

  rcs_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_beat_o      (push_beat)
  );

  rcs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_beat_i (push_beat),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_beat_o  (pop_beat)
  );

  rcs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .q_valid_i     (q_valid),
    .q_beat_i      (pop_beat),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
